// File: rtl/cht_pkg.sv
package cht_pkg;

  localparam int NumBuckets = 16;
  localparam int NumNodes = 64;
  localparam int BucketW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
  localparam int LinkW = $clog2(NumNodes + 1);
  localparam int NodeW = (NumNodes > 1) ? $clog2(NumNodes) : 1;
  localparam int OpW = 2;
  localparam int KeyW = 31;
  localparam int ValW = 32;
  localparam int CountW = 7;

  localparam logic [LinkW-1:0] Nil = LinkW'(NumNodes);

  localparam logic [OpW-1:0] OpPut = 2'd0;
  localparam logic [OpW-1:0] OpGet = 2'd1;
  localparam logic [OpW-1:0] OpRemove = 2'd2;

  typedef enum logic [2:0] {
    CmdNone,
    CmdLoad,
    CmdRead,
    CmdStep,
    CmdCommit,
    CmdFinish
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctrl_t;

  typedef struct packed {
    logic at_end;
    logic hit;
  } stat_t;

endpackage

// File: rtl/cht_ctrl.sv
module cht_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  cht_pkg::stat_t stat,
  output cht_pkg::ctrl_t ctrl
);

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCheck,
    StCommit,
    StDone
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctrl.cmd = cht_pkg::CmdNone;
    unique case (state_r)
      StIdle: begin
        if (start) begin
          ctrl.cmd = cht_pkg::CmdLoad;
          state_nxt = StRead;
        end
      end
      StRead: begin
        if (stat.at_end) begin
          state_nxt = StCommit;
        end else begin
          ctrl.cmd = cht_pkg::CmdRead;
          state_nxt = StCheck;
        end
      end
      StCheck: begin
        if (stat.hit) begin
          state_nxt = StCommit;
        end else begin
          ctrl.cmd = cht_pkg::CmdStep;
          state_nxt = StRead;
        end
      end
      StCommit: begin
        ctrl.cmd = cht_pkg::CmdCommit;
        state_nxt = StDone;
      end
      StDone: begin
        ctrl.cmd = cht_pkg::CmdFinish;
        state_nxt = StIdle;
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != StIdle);

  a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.cmd == cht_pkg::CmdLoad) |=> (state_r == StRead))
    else $error("load did not enter chain walk");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StDone) |=> (state_r == StIdle))
    else $error("finish did not return to idle");
  a_commit_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StCommit) |=> (state_r == StDone))
    else $error("commit not followed by done");

endmodule

// File: rtl/cht_datapath.sv
module cht_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cht_pkg::ctrl_t                ctrl,
  output cht_pkg::stat_t                stat,
  input  logic [cht_pkg::OpW-1:0]       in_operation,
  input  logic [cht_pkg::KeyW-1:0]      in_key,
  input  logic [cht_pkg::ValW-1:0]      in_value,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [cht_pkg::ValW-1:0]      out_read_value,
  output logic                          out_status,
  output logic [cht_pkg::CountW-1:0]    out_count
);

  localparam int LW = cht_pkg::LinkW;
  localparam int NW = cht_pkg::NodeW;
  localparam int BW = cht_pkg::BucketW;

  logic [cht_pkg::KeyW-1:0] mem_key [cht_pkg::NumNodes];
  logic [cht_pkg::ValW-1:0] mem_val [cht_pkg::NumNodes];
  logic [LW-1:0]            mem_link [cht_pkg::NumNodes];
  logic [LW-1:0]            heads_r [cht_pkg::NumBuckets];

  logic [cht_pkg::OpW-1:0]  op_r;
  logic [cht_pkg::KeyW-1:0] key_r;
  logic [cht_pkg::ValW-1:0] val_r;
  logic [BW-1:0]            bkt_r;
  logic [LW-1:0]            cur_r;
  logic [LW-1:0]            prev_r;
  logic [LW-1:0]            steps_r;
  logic [cht_pkg::KeyW-1:0] rd_key_r;
  logic [cht_pkg::ValW-1:0] rd_val_r;
  logic [LW-1:0]            rd_link_r;
  logic [LW-1:0]            free_r;
  logic [LW-1:0]            unused_r;
  logic [LW-1:0]            count_r;
  logic [LW-1:0]            free_link_r;
  logic                     hit;
  logic                     valid_op;
  logic [LW-1:0]            alloc;
  logic                     out_valid_r;
  logic                     out_found_r;
  logic [cht_pkg::ValW-1:0] out_val_r;
  logic                     out_status_r;

  assign hit = (rd_key_r == key_r);
  assign valid_op = (op_r == cht_pkg::OpPut) || (op_r == cht_pkg::OpGet) ||
                    (op_r == cht_pkg::OpRemove);
  assign stat.hit = hit;
  assign stat.at_end = !valid_op || (cur_r >= cht_pkg::Nil) ||
                       (steps_r >= cht_pkg::Nil);
  assign alloc = (free_r != cht_pkg::Nil) ? free_r :
                 ((unused_r < cht_pkg::Nil) ? unused_r : cht_pkg::Nil);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cht_pkg::NumBuckets; i++) begin
        heads_r[i] <= cht_pkg::Nil;
      end
      free_r <= cht_pkg::Nil;
      unused_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (ctrl.cmd)
        cht_pkg::CmdLoad: begin
          op_r <= in_operation;
          key_r <= in_key;
          val_r <= in_value;
          bkt_r <= BW'(in_key % cht_pkg::NumBuckets);
          cur_r <= heads_r[BW'(in_key % cht_pkg::NumBuckets)];
          prev_r <= cht_pkg::Nil;
          steps_r <= '0;
          free_link_r <= (free_r != cht_pkg::Nil) ? mem_link[free_r[NW-1:0]]
                                                  : cht_pkg::Nil;
        end
        cht_pkg::CmdRead: begin
          rd_key_r <= mem_key[cur_r[NW-1:0]];
          rd_val_r <= mem_val[cur_r[NW-1:0]];
          rd_link_r <= mem_link[cur_r[NW-1:0]];
        end
        cht_pkg::CmdStep: begin
          prev_r <= cur_r;
          cur_r <= rd_link_r;
          steps_r <= steps_r + 1'b1;
        end
        cht_pkg::CmdCommit: begin
          out_found_r <= 1'b0;
          out_val_r <= '0;
          out_status_r <= 1'b0;
          if (valid_op && !stat.at_end) begin
            out_found_r <= 1'b1;
            if (op_r == cht_pkg::OpPut) begin
              mem_val[cur_r[NW-1:0]] <= val_r;
            end else if (op_r == cht_pkg::OpGet) begin
              out_val_r <= rd_val_r;
            end else begin
              if (prev_r != cht_pkg::Nil) begin
                mem_link[prev_r[NW-1:0]] <= rd_link_r;
              end else begin
                heads_r[bkt_r] <= rd_link_r;
              end
              mem_link[cur_r[NW-1:0]] <= free_r;
              free_r <= cur_r;
              if (count_r != '0) begin
                count_r <= count_r - 1'b1;
              end
            end
          end else if (op_r == cht_pkg::OpPut) begin
            if (alloc != cht_pkg::Nil) begin
              if (free_r != cht_pkg::Nil) begin
                free_r <= free_link_r;
              end else begin
                unused_r <= unused_r + 1'b1;
              end
              mem_key[alloc[NW-1:0]] <= key_r;
              mem_val[alloc[NW-1:0]] <= val_r;
              mem_link[alloc[NW-1:0]] <= heads_r[bkt_r];
              heads_r[bkt_r] <= alloc;
              count_r <= count_r + 1'b1;
            end else begin
              out_status_r <= 1'b1;
            end
          end
        end
        cht_pkg::CmdFinish: begin
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_read_value = out_val_r;
  assign out_status = out_status_r;
  assign out_count = cht_pkg::CountW'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cht_pkg::Nil)
    else $error("entry count above pool size");
  a_status_put: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (op_r == cht_pkg::OpPut && !out_found_r))
    else $error("pool-full flag on a non-put or hit");
  a_value_get: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_val_r != '0) |-> (op_r == cht_pkg::OpGet && out_found_r))
    else $error("value reported without a get hit");

endmodule

// File: rtl/chained_hash_table.sv
// Key-value table with separate chaining: the bucket is the key modulo 16,
// and 64 nodes are shared by all buckets. Assert start while busy is low to
// begin a put, get or remove; out_valid then pulses for one cycle with the
// result, which the receiver must take in that cycle since it cannot stall.
// The walk reads the chain one node at a time, with a read state and then a
// check state per node, until the key matches or the chain ends; an unused
// operation code reads no node. A commit state and a done state follow, and
// out_valid is high in the first cycle in which busy is low again. A new
// start can be accepted in that cycle.
module chained_hash_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cht_pkg::OpW-1:0]       in_operation,
  input  logic [cht_pkg::KeyW-1:0]      in_key,
  input  logic [cht_pkg::ValW-1:0]      in_value,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [cht_pkg::ValW-1:0]      out_read_value,
  output logic                          out_status,
  output logic [cht_pkg::CountW-1:0]    out_count
);

  cht_pkg::ctrl_t ctrl;
  cht_pkg::stat_t stat;

  cht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  cht_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_operation   (in_operation),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

endmodule

// File: verif/cht_checker.sv
module cht_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [cht_pkg::OpW-1:0]    in_operation,
  input  logic [cht_pkg::KeyW-1:0]   in_key,
  input  logic [cht_pkg::ValW-1:0]   in_value,
  input  logic                       out_valid,
  input  logic                       out_found,
  input  logic [cht_pkg::ValW-1:0]   out_read_value,
  input  logic                       out_status,
  input  logic [cht_pkg::CountW-1:0] out_count,
  output int                         fail_count,
  output int                         pending
);
  import cht_pkg::*;

  typedef struct packed {
    logic              found;
    logic [ValW-1:0]   read_value;
    logic              status;
    logic [CountW-1:0] count;
  } reply_t;

  logic [LinkW-1:0]  heads[NumBuckets];
  logic [KeyW-1:0]   keys[NumNodes];
  logic [ValW-1:0]   vals[NumNodes];
  logic [LinkW-1:0]  links[NumNodes];
  logic [LinkW-1:0]  free_list;
  int                fresh;
  int                entries;
  reply_t            replies[$];

  function automatic reply_t apply_op(logic [OpW-1:0] op, logic [KeyW-1:0] key,
                                      logic [ValW-1:0] val);
    reply_t r;
    int b;
    int cur;
    int pre;
    int hit;
    int n;
    int steps;
    r = '0;
    b = key % NumBuckets;
    cur = heads[b];
    pre = Nil;
    hit = Nil;
    steps = 0;
    if (op == OpPut || op == OpGet || op == OpRemove) begin
      while (cur < Nil && steps < NumNodes && hit == Nil) begin
        if (keys[cur] == key) hit = cur;
        else begin
          pre = cur;
          cur = links[cur];
        end
        steps++;
      end
      r.found = hit < Nil;
      if (op == OpPut) begin
        if (hit < Nil) vals[hit] = val;
        else begin
          n = Nil;
          if (free_list < Nil) begin
            n = free_list;
            free_list = links[n];
          end else if (fresh < NumNodes) begin
            n = fresh;
            fresh++;
          end
          if (n < Nil) begin
            keys[n] = key;
            vals[n] = val;
            links[n] = heads[b];
            heads[b] = n;
            entries++;
          end else r.status = 1'b1;
        end
      end else if (op == OpGet) begin
        if (hit < Nil) r.read_value = vals[hit];
      end else if (hit < Nil) begin
        if (pre < Nil) links[pre] = links[hit];
        else heads[b] = links[hit];
        links[hit] = free_list;
        free_list = hit;
        if (entries > 0) entries--;
      end
    end
    r.count = entries[CountW-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      for (int i = 0; i < NumBuckets; i++) heads[i] = Nil;
      free_list = Nil;
      fresh = 0;
      entries = 0;
      fail_count <= 0;
      replies.delete();
      pending <= 0;
    end else begin
      if (out_valid) begin
        got = '{out_found, out_read_value, out_status, out_count};
        if (replies.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = replies.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected found=%b value=%h status=%b count=%0d",
                     $time, want.found, want.read_value, want.status, want.count);
            $display("%0t:          actual   found=%b value=%h status=%b count=%0d",
                     $time, got.found, got.read_value, got.status, got.count);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) replies.push_back(apply_op(in_operation, in_key, in_value));
      pending <= replies.size();
    end
  end
endmodule

// File: verif/tb_chained_hash_table.sv
module tb_chained_hash_table;
  import cht_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [OpW-1:0]    in_operation;
  logic [KeyW-1:0]   in_key;
  logic [ValW-1:0]   in_value;
  logic              out_valid;
  logic              out_found;
  logic [ValW-1:0]   out_read_value;
  logic              out_status;
  logic [CountW-1:0] out_count;
  int                fail_count;
  int                pending;
  int                idle_pct;
  int                quiet_cycles;
  logic [KeyW-1:0]   key_pool[8];

  localparam int WatchdogLimit = 5000;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  chained_hash_table i_dut (.*);

  cht_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic issue(logic [OpW-1:0] op, logic [KeyW-1:0] key, logic [ValW-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_key <= key;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [KeyW-1:0] pick_key(int mode);
    logic [KeyW-1:0] k;
    case (mode)
      0: k = key_pool[$urandom_range(7)];
      1: k = KeyW'({$urandom, $urandom});
      default: k = KeyW'(($urandom_range(5) << 4) | 3);
    endcase
    return k;
  endfunction

  initial begin
    logic [OpW-1:0] op;
    start = 1'b0;
    in_operation = OpGet;
    in_key = '0;
    in_value = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    issue(OpGet, 31'd5, '1);
    issue(OpRemove, 31'd5, '0);
    issue(OpPut, 31'd0, 32'h0);
    issue(OpPut, {KeyW{1'b1}}, '1);
    issue(OpPut, 31'd16, 32'hA5A5_5A5A);
    issue(OpPut, 31'd32, 32'h1234_5678);
    issue(OpGet, 31'd16, '0);
    issue(OpPut, 31'd16, 32'hDEAD_BEEF);
    issue(OpGet, 31'd16, '0);
    issue(OpRemove, 31'd16, '0);
    issue(OpGet, 31'd16, '0);
    issue(OpRemove, 31'd32, '0);
    issue(OpRemove, 31'd0, '0);
    issue(OpGet, {KeyW{1'b1}}, '0);
    issue(OpUnused, 31'd7, '1);
    issue(OpGet, 31'd48, '0);
    for (int i = 0; i < 8; i++) begin
      key_pool[i] = KeyW'(($urandom_range(3) << 4) | $urandom_range(15));
    end
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 7;
        default: idle_pct = 0;
      endcase
      if (phase == 2) begin
        for (int i = 0; i < 70; i++) issue(OpPut, KeyW'(1000 + i), $urandom);
        issue(OpPut, 31'd1000, 32'h1);
        issue(OpPut, 31'd5000, 32'h2);
        for (int i = 0; i < 70; i++) issue(OpRemove, KeyW'(1000 + i), '0);
      end else begin
        for (int i = 0; i < 110; i++) begin
          case ($urandom_range(9))
            0, 1, 2, 3: op = OpPut;
            4, 5, 6: op = OpGet;
            7, 8: op = OpRemove;
            default: op = OpW'($urandom_range(3));
          endcase
          issue(op, pick_key($urandom_range(9) < 7 ? 0 : $urandom_range(1, 2)), $urandom);
        end
      end
      drain();
    end
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
